[rtl/ps2_mouse_packet_decoder_macros.svh]
// Assertion macros for the PS/2 mouse packet decoder checker.
// Depends on nothing; the including scope provides clk and rst_n.
`ifndef PS2_MOUSE_PACKET_DECODER_MACROS_SVH
`define PS2_MOUSE_PACKET_DECODER_MACROS_SVH

// Checked only outside reset.
`define PMPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PMPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pmpd_pkg.sv]
// Shared types and constants of the PS/2 mouse packet decoder.
// No dependencies.
`default_nettype none
package pmpd_pkg;

  localparam int PACKET_LENGTH = 3;
  localparam int BYTE_POS_W    = 2;
  localparam int AUX_BIT       = 5;
  localparam int POS_W         = 7;
  localparam int CFG_INDEX_W   = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_COLUMNS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_ROWS    = 8'd1;

  localparam logic [7:0]       GRID_COLUMNS_RST = 8'd80;
  localparam logic [7:0]       GRID_ROWS_RST    = 8'd25;
  localparam logic [POS_W-1:0] POS_X_RST        = 7'd40;
  localparam logic [POS_W-1:0] POS_Y_RST        = 7'd12;

  localparam logic [1:0] EV_BUTTON_DOWN = 2'd0;
  localparam logic [1:0] EV_BUTTON_UP   = 2'd1;
  localparam logic [1:0] EV_MOVE        = 2'd2;

  typedef struct packed {
    logic [2:0]       changed;
    logic [2:0]       prev_buttons;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } pmpd_job_t;

endpackage
`default_nettype wire

[rtl/pmpd_queue.sv]
// Small FIFO of decoded packet jobs between front and back.
// Depends on pmpd_pkg. DEPTH must be 2 or more.
`default_nettype none
module pmpd_queue import pmpd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  pmpd_job_t      push_job,
  output logic           not_full,
  input  wire logic      pop,
  output logic           not_empty,
  output pmpd_job_t      head_job
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pmpd_job_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign not_full  = (count_r != CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = mem_r[rd_ptr_r];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

[rtl/pmpd_front.sv]
// Front end: config registers, byte filter, packet assembly, cursor clamp
// and button change detection. Depends on pmpd_pkg.
`default_nettype none
module pmpd_front import pmpd_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             status_byte,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]             cfg_data,
  input  wire logic                   q_not_full,
  output logic                        q_push,
  output pmpd_job_t                   q_job
);

  logic [7:0]            cols_r, cols_nxt;
  logic [7:0]            rows_r, rows_nxt;
  logic [BYTE_POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0]      x_r, x_nxt;
  logic [POS_W-1:0]      y_r, y_nxt;
  logic [2:0]            btn_r, btn_nxt;
  logic [7:0]            b0_r, b1_r;
  logic                  take, last_byte;
  logic signed [9:0]     sum_x, sum_y;
  logic [POS_W-1:0]      new_x, new_y;

  function automatic logic [POS_W-1:0] clamp_axis(input logic signed [9:0] v,
                                                  input logic [7:0] size);
    logic [7:0] lim;
    lim = size;
    if (size == 8'd0) begin
      lim = 8'd1;
    end else if (size > 8'd128) begin
      lim = 8'd128;
    end
    if (v < 0) begin
      return '0;
    end else if (v >= $signed({2'b00, lim})) begin
      return POS_W'(lim - 8'd1);
    end else begin
      return v[POS_W-1:0];
    end
  endfunction

  assign in_ready  = q_not_full;
  assign cfg_ready = 1'b1;
  assign take      = in_valid && in_ready && status_byte[AUX_BIT];
  assign last_byte = (pos_r >= BYTE_POS_W'(PACKET_LENGTH - 1));

  assign sum_x = $signed({3'b000, x_r}) + $signed({{2{b1_r[7]}}, b1_r});
  assign sum_y = $signed({3'b000, y_r}) - $signed({{2{data_byte[7]}}, data_byte});
  assign new_x = clamp_axis(sum_x, cols_r);
  assign new_y = clamp_axis(sum_y, rows_r);

  assign q_push             = take && last_byte;
  assign q_job.changed      = b0_r[2:0] ^ btn_r;
  assign q_job.prev_buttons = btn_r;
  assign q_job.pos_x        = new_x;
  assign q_job.pos_y        = new_y;

  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    pos_nxt  = pos_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    btn_nxt  = btn_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_GRID_COLUMNS) begin
        cols_nxt = cfg_data;
      end else if (cfg_index == CFG_GRID_ROWS) begin
        rows_nxt = cfg_data;
      end
    end
    if (take) begin
      if (last_byte) begin
        pos_nxt = '0;
        x_nxt   = new_x;
        y_nxt   = new_y;
        btn_nxt = b0_r[2:0];
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= GRID_COLUMNS_RST;
      rows_r <= GRID_ROWS_RST;
      pos_r  <= '0;
      x_r    <= POS_X_RST;
      y_r    <= POS_Y_RST;
      btn_r  <= '0;
    end else begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
      pos_r  <= pos_nxt;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      btn_r  <= btn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !last_byte) begin
      if (pos_r == '0) begin
        b0_r <= data_byte;
      end else begin
        b1_r <= data_byte;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/pmpd_back.sv]
// Back end: walks one packet job into button events and a final move event,
// one per cycle unless stalled, through an output register. Depends on pmpd_pkg.
`default_nettype none
module pmpd_back import pmpd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_not_empty,
  input  pmpd_job_t       q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      event_kind,
  output logic [1:0]      button_number,
  output logic [POS_W-1:0] cursor_x,
  output logic [POS_W-1:0] cursor_y,
  output logic            last_of_run
);

  logic             busy_r, busy_nxt;
  pmpd_job_t        job_r, job_nxt;
  pmpd_job_t        cur;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [1:0]       btn_num_r, btn_num_nxt;
  logic [POS_W-1:0] ox_r, ox_nxt;
  logic [POS_W-1:0] oy_r, oy_nxt;
  logic             last_r, last_nxt;
  logic             slot_free, advance;
  logic [1:0]       sel;
  logic [2:0]       sel_mask;

  assign cur       = busy_r ? job_r : q_head;
  assign slot_free = !out_valid_r || out_ready;
  assign advance   = slot_free && (busy_r || q_not_empty);
  assign q_pop     = advance && !busy_r;

  always_comb begin
    priority if (cur.changed[0]) begin
      sel = 2'd1;
    end else if (cur.changed[1]) begin
      sel = 2'd2;
    end else if (cur.changed[2]) begin
      sel = 2'd3;
    end else begin
      sel = 2'd0;
    end
  end

  assign sel_mask = (sel == 2'd0) ? 3'b000 : 3'(3'b001 << (sel - 2'd1));

  always_comb begin
    busy_nxt      = busy_r;
    job_nxt       = job_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    btn_num_nxt   = btn_num_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    last_nxt      = last_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      ox_nxt        = cur.pos_x;
      oy_nxt        = cur.pos_y;
      if (sel != 2'd0) begin
        kind_nxt    = ((cur.prev_buttons & sel_mask) != 3'b000) ? EV_BUTTON_UP
                                                                : EV_BUTTON_DOWN;
        btn_num_nxt = sel;
        last_nxt    = 1'b0;
        busy_nxt    = 1'b1;
        job_nxt     = cur;
        job_nxt.changed = cur.changed & ~sel_mask;
      end else begin
        kind_nxt    = EV_MOVE;
        btn_num_nxt = 2'd0;
        last_nxt    = 1'b1;
        busy_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    kind_r    <= kind_nxt;
    btn_num_r <= btn_num_nxt;
    ox_r      <= ox_nxt;
    oy_r      <= oy_nxt;
    last_r    <= last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign event_kind    = kind_r;
  assign button_number = btn_num_r;
  assign cursor_x      = ox_r;
  assign cursor_y      = oy_r;
  assign last_of_run   = last_r;

endmodule
`default_nettype wire

[rtl/ps2_mouse_packet_decoder.sv]
// PS/2 mouse packet decoder: one input beat per cycle while the packet queue
// has room; a third aux byte's packet job passes the queue register and then
// the output register before its first event. A packet yields 1 to 4 events,
// one per cycle unless out_tready stalls; later packets queue up behind them.
// Synchronous active-low reset: grid 80x25, cursor (40,12), no buttons held.
// Depends on pmpd_pkg, pmpd_front, pmpd_queue, pmpd_back.
`default_nettype none
module ps2_mouse_packet_decoder import pmpd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,   // [7:0] data_byte
  input  wire logic [7:0]             in_tuser,   // [7:0] status_byte
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [15:0]                 out_tdata,  // [1:0] button_number, [8:2] cursor_x,
                                                  // [15:9] cursor_y
  output logic [1:0]                  out_tuser,  // [1:0] event_kind
  output logic                        out_tlast,  // last_of_run
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]             cfg_data
);

  logic             q_not_full, q_not_empty, q_push, q_pop;
  pmpd_job_t        q_in_job, q_head;
  logic [1:0]       button_number;
  logic [POS_W-1:0] cursor_x, cursor_y;

  pmpd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .status_byte (in_tuser),
    .data_byte   (in_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_not_full  (q_not_full),
    .q_push      (q_push),
    .q_job       (q_in_job)
  );

  pmpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_in_job),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (q_head)
  );

  pmpd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .event_kind    (out_tuser),
    .button_number (button_number),
    .cursor_x      (cursor_x),
    .cursor_y      (cursor_y),
    .last_of_run   (out_tlast)
  );

  assign out_tdata = {cursor_y, cursor_x, button_number};

endmodule
`default_nettype wire

[rtl/ps2_mouse_packet_decoder_checker.sv]
// Port-level checker for the PS/2 mouse packet decoder, bound to the top.
// Depends on ps2_mouse_packet_decoder_macros.svh.
`default_nettype none
`include "ps2_mouse_packet_decoder_macros.svh"
module ps2_mouse_packet_decoder_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  `PMPD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled beat changed")
  `PMPD_ASSERT(a_last_is_move, out_tvalid |-> (out_tlast == (out_tuser == 2'd2)), "tlast does not match move event")
  `PMPD_ASSERT(a_button_field, out_tvalid |-> ((out_tdata[1:0] == 2'd0) == out_tlast), "button number inconsistent with event")
  `PMPD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind ps2_mouse_packet_decoder ps2_mouse_packet_decoder_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

[bench/ps2_mouse_packet_decoder_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for ps2_mouse_packet_decoder: aux/non-aux byte stream in,
// button and move event beats out, checked against an in-bench packet decoder.
// Depends on pmpd_pkg and the ps2_mouse_packet_decoder RTL.
module ps2_mouse_packet_decoder_tb;
  import pmpd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 250;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_AUX      = 36;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       button;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             last_beat;
  } mouse_event_t;

  typedef struct packed {
    logic [7:0]       status;
    logic [7:0]       data;
    logic             typed;
    logic [POS_W-1:0] tx;
    logic [POS_W-1:0] ty;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;   // [7:0] data_byte
  logic [7:0]             in_tuser = '0;   // [7:0] status_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [15:0]            out_tdata;       // [1:0] button_number, [8:2] cursor_x, [15:9] cursor_y
  logic [1:0]             out_tuser;       // [1:0] event_kind
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data = '0;

  // typed expectation riding along with the beat on the wire
  logic                   drv_typed = 1'b0;
  logic [POS_W-1:0]       drv_tx = '0;
  logic [POS_W-1:0]       drv_ty = '0;

  // decoder state
  logic [7:0]             grid_cols;
  logic [7:0]             grid_rows;
  logic [1:0]             pkt_idx;
  logic [7:0]             pkt_buf [PACKET_LENGTH];
  logic [POS_W-1:0]       cur_x;
  logic [POS_W-1:0]       cur_y;
  logic [2:0]             held_buttons;
  mouse_event_t           pending_events [$];

  int                     errs = 0;
  int                     idle_cycles = 0;
  int                     burst_left = 0;
  int                     stream_pos = 0;
  bit                     no_gaps = 1'b0;
  int                     hold_requests = 0;
  int                     hold_seen = 0;
  int                     hold_left = 0;
  logic [8:0]             rx_tick = '0;

  stim_row_t directed_rows [21] = '{
    '{8'h00, 8'hFF, 1'b0, 7'd0,  7'd0},
    '{8'hDF, 8'h07, 1'b0, 7'd0,  7'd0},
    '{8'h20, 8'h00, 1'b0, 7'd0,  7'd0},
    '{8'h20, 8'h00, 1'b0, 7'd0,  7'd0},
    '{8'h20, 8'h00, 1'b1, 7'd40, 7'd12},
    '{8'h20, 8'h07, 1'b0, 7'd0,  7'd0},
    '{8'h20, 8'h7F, 1'b0, 7'd0,  7'd0},
    '{8'h20, 8'h80, 1'b1, 7'd79, 7'd24},
    '{8'h20, 8'hF8, 1'b0, 7'd0,  7'd0},
    '{8'h1F, 8'h55, 1'b0, 7'd0,  7'd0},
    '{8'h20, 8'h80, 1'b0, 7'd0,  7'd0},
    '{8'hFF, 8'h7F, 1'b1, 7'd0,  7'd0},
    '{8'h20, 8'h05, 1'b0, 7'd0,  7'd0},
    '{8'h20, 8'h01, 1'b0, 7'd0,  7'd0},
    '{8'h20, 8'hFF, 1'b0, 7'd0,  7'd0},
    '{8'h20, 8'h02, 1'b0, 7'd0,  7'd0},
    '{8'h20, 8'h00, 1'b0, 7'd0,  7'd0},
    '{8'h20, 8'h00, 1'b0, 7'd0,  7'd0},
    '{8'h20, 8'h00, 1'b0, 7'd0,  7'd0},
    '{8'h20, 8'hFF, 1'b0, 7'd0,  7'd0},
    '{8'h20, 8'h01, 1'b0, 7'd0,  7'd0}
  };

  ps2_mouse_packet_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [POS_W-1:0] clamp_to_grid(input int v, input logic [7:0] size);
    int lim;
    lim = size;
    if (lim < 1) lim = 1;
    if (lim > 128) lim = 128;
    if (v < 0) return '0;
    if (v >= lim) return POS_W'(lim - 1);
    return POS_W'(v);
  endfunction

  task automatic reset_predictor();
    grid_cols = GRID_COLUMNS_RST;
    grid_rows = GRID_ROWS_RST;
    pkt_idx = '0;
    cur_x = POS_X_RST;
    cur_y = POS_Y_RST;
    held_buttons = '0;
    pending_events.delete();
  endtask

  task automatic decode_mouse_byte(input logic [7:0] status, input logic [7:0] data,
                                   input logic typed, input logic [POS_W-1:0] tx,
                                   input logic [POS_W-1:0] ty);
    int px, py, dx, dy;
    logic [2:0] btns;
    logic [POS_W-1:0] ex, ey;
    mouse_event_t ev;
    if (!status[AUX_BIT]) return;
    if (pkt_idx < PACKET_LENGTH - 1) begin
      pkt_buf[pkt_idx] = data;
      pkt_idx = pkt_idx + 2'd1;
      return;
    end
    pkt_buf[PACKET_LENGTH - 1] = data;
    pkt_idx = '0;
    px = cur_x;
    py = cur_y;
    dx = $signed(pkt_buf[1]);
    dy = $signed(pkt_buf[2]);
    cur_x = clamp_to_grid(px + dx, grid_cols);
    cur_y = clamp_to_grid(py - dy, grid_rows);
    ex = typed ? tx : cur_x;
    ey = typed ? ty : cur_y;
    btns = pkt_buf[0][2:0];
    for (int i = 0; i < 3; i++) begin
      if (btns[i] != held_buttons[i]) begin
        ev.kind = held_buttons[i] ? EV_BUTTON_UP : EV_BUTTON_DOWN;
        ev.button = 2'(i + 1);
        ev.x = ex;
        ev.y = ey;
        ev.last_beat = 1'b0;
        pending_events.push_back(ev);
      end
    end
    ev.kind = EV_MOVE;
    ev.button = 2'd0;
    ev.x = ex;
    ev.y = ey;
    ev.last_beat = 1'b1;
    pending_events.push_back(ev);
    held_buttons = btns;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  // predictor update on input and config beats, compare on output beats, watchdog
  always @(posedge clk) begin
    mouse_event_t ev;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GRID_COLUMNS: grid_cols = cfg_data;
          CFG_GRID_ROWS:    grid_rows = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        decode_mouse_byte(in_tuser, in_tdata, drv_typed, drv_tx, drv_ty);
      if (out_tvalid && out_tready) begin
        if (pending_events.size() == 0) begin
          $error("event beat with none pending: kind %0d button %0d x %0d y %0d last %0d",
                 out_tuser, out_tdata[1:0], out_tdata[8:2], out_tdata[15:9], out_tlast);
          errs++;
        end else begin
          ev = pending_events.pop_front();
          check_field("event_kind", 8'(ev.kind), 8'(out_tuser));
          check_field("button_number", 8'(ev.button), 8'(out_tdata[1:0]));
          check_field("cursor_x", 8'(ev.x), 8'(out_tdata[8:2]));
          check_field("cursor_y", 8'(ev.y), 8'(out_tdata[15:9]));
          check_field("last_of_run", 8'(ev.last_beat), 8'(out_tlast));
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $error("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // output backpressure: rotating stall patterns plus requested long hold-offs
  always @(posedge clk) begin
    rx_tick <= rx_tick + 9'd1;
    if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (rx_tick[8:7])
        2'd0:    out_tready <= 1'b1;
        2'd1:    out_tready <= ($urandom_range(0, 3) != 0);
        2'd2:    out_tready <= (rx_tick[2:0] > 3'd2);
        default: out_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  task automatic offer_byte(input logic [7:0] status, input logic [7:0] data,
                            input logic typed = 1'b0, input logic [POS_W-1:0] tx = '0,
                            input logic [POS_W-1:0] ty = '0);
    if (!no_gaps && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    if (status[AUX_BIT]) stream_pos = (stream_pos == PACKET_LENGTH - 1) ? 0 : stream_pos + 1;
    in_tvalid <= 1'b1;
    in_tuser <= status;
    in_tdata <= data;
    drv_typed <= typed;
    drv_tx <= tx;
    drv_ty <= ty;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [7:0] aux_status();
    return 8'($urandom) | 8'h20;
  endfunction

  function automatic logic [7:0] noise_status();
    return 8'($urandom) & ~8'h20;
  endfunction

  // half full-range, half small steps so the cursor also wanders inside the grid
  function automatic logic [7:0] rand_delta();
    logic [7:0] v;
    if ($urandom_range(0, 1)) return 8'($urandom);
    v = 8'($urandom_range(0, 8));
    return v - 8'd4;
  endfunction

  task automatic send_mouse_traffic(input int aux_target);
    int aux_sent;
    int pick;
    logic [7:0] pkt [PACKET_LENGTH];
    aux_sent = 0;
    while (aux_sent < aux_target) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        while (stream_pos != 0) begin
          offer_byte(aux_status(), 8'($urandom));
          aux_sent++;
        end
        pkt[0] = 8'($urandom);
        pkt[1] = rand_delta();
        pkt[2] = rand_delta();
        for (int k = 0; k < PACKET_LENGTH; k++) begin
          if ($urandom_range(0, 9) == 0) offer_byte(noise_status(), 8'($urandom));
          offer_byte(aux_status(), pkt[k]);
        end
        aux_sent += PACKET_LENGTH;
      end else if (pick < 90) begin
        offer_byte(noise_status(), 8'($urandom));
      end else begin
        offer_byte(aux_status(), 8'($urandom));
        aux_sent++;
      end
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(input logic [7:0] cols, input logic [7:0] rows);
    wait_idle();
    write_reg(CFG_GRID_COLUMNS, cols);
    write_reg(CFG_GRID_ROWS, rows);
  endtask

  initial begin
    reset_predictor();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < $size(directed_rows); r++)
      offer_byte(directed_rows[r].status, directed_rows[r].data, directed_rows[r].typed,
                 directed_rows[r].tx, directed_rows[r].ty);

    // long output hold-off while the input keeps streaming back to back
    set_grid(8'd128, 8'd128);
    send_mouse_traffic(15);
    hold_requests <= hold_requests + 1;
    no_gaps = 1'b1;
    send_mouse_traffic(30);
    no_gaps = 1'b0;

    set_grid(8'd1, 8'd1);
    send_mouse_traffic(PHASE_AUX);
    set_grid(8'd0, 8'd255);
    send_mouse_traffic(PHASE_AUX);
    set_grid(8'd255, 8'd0);
    send_mouse_traffic(PHASE_AUX);
    set_grid(8'($urandom_range(1, 128)), 8'($urandom_range(1, 128)));
    send_mouse_traffic(PHASE_AUX);
    set_grid(8'($urandom_range(1, 128)), 8'($urandom_range(1, 128)));
    send_mouse_traffic(PHASE_AUX);

    wait_idle();
    if (pending_events.size() != 0) begin
      $error("%0d events never arrived", pending_events.size());
      errs++;
    end
    if (errs == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/pmpd_pkg.sv
rtl/pmpd_queue.sv
rtl/pmpd_front.sv
rtl/pmpd_back.sv
rtl/ps2_mouse_packet_decoder.sv
rtl/ps2_mouse_packet_decoder_checker.sv
bench/ps2_mouse_packet_decoder_tb.sv
